[hw/rtl/hhls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhls_pkg
// Shared types, constants and helpers of the http header length scanner.
// ----------------------------------------------------------------------------
package hhls_pkg;

    localparam int TOK_DEPTH = 4;
    localparam int TOK_AW    = 2;
    localparam int TOK_CW    = 3;
    localparam int RES_DEPTH = 2;
    localparam int RES_CW    = 2;
    localparam int COUNT_W   = 22;
    localparam int LEN_W     = 27;
    localparam int LIMIT_W   = 21;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 21'd8192;
    localparam logic [LEN_W-1:0]   MAX_LEN       = 27'd67108864;
    localparam logic [LEN_W-1:0]   MAX_LEN_DIV10 = 27'd6710886;
    localparam logic [3:0]         PREFIX_LEN    = 4'd15;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_LEADWS,
        PH_DIGITS,
        PH_TRAILWS,
        PH_OTHER,
        PH_BAD
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BADLINE   = 3'd1,
        ST_TOOLARGE  = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // one word from the front: end of line, or one or two content bytes
    typedef struct packed {
        logic       eol;
        logic       cr_first;
        logic [7:0] data;
    } token_t;

    typedef struct packed {
        status_t          status;
        logic             has_length;
        logic [LEN_W-1:0] body_length;
    } result_t;

    typedef struct packed {
        logic               in_hdr;
        logic [1:0]         space_cnt;
        logic               nonempty;
        logic [COUNT_W-1:0] count;
        phase_t             phase;
        logic [3:0]         pidx;
        logic [LEN_W-1:0]   acc;
    } line_t;

    localparam line_t LINE_RESET = '{
        in_hdr:    1'b0,
        space_cnt: 2'd0,
        nonempty:  1'b0,
        count:     '0,
        phase:     PH_PREFIX,
        pidx:      4'd0,
        acc:       '0
    };

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // saturating add; the count only feeds a compare against a 21-bit limit
    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [1:0] n);
        logic [COUNT_W:0] sum;
        sum = {1'b0, a} + (COUNT_W+1)'(n);
        return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
    endfunction

    function automatic line_t take_content(input line_t s, input logic [7:0] c);
        line_t            r;
        logic [7:0]       lc;
        logic             is_ws;
        logic             is_dig;
        logic [LEN_W-1:0] acc_new;
        r          = s;
        r.nonempty = 1'b1;
        r.count    = sat_add(s.count, 2'd1);
        lc         = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        is_ws      = (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
        is_dig     = (c >= 8'h30 && c <= 8'h39);
        acc_new    = (s.acc << 3) + (s.acc << 1) + LEN_W'(c[3:0]);
        if (!s.in_hdr) begin
            if (c == CHAR_SPACE && s.space_cnt < 2'd2)
                r.space_cnt = s.space_cnt + 2'd1;
        end
        else begin
            case (s.phase) inside
                PH_PREFIX:
                begin
                    if (s.pidx != PREFIX_LEN && lc == prefix_char(s.pidx))
                    begin
                        r.pidx = s.pidx + 4'd1;
                        if (s.pidx == PREFIX_LEN - 4'd1)
                            r.phase = PH_LEADWS;
                    end
                    else
                        r.phase = PH_OTHER;
                end
                PH_LEADWS, PH_DIGITS:
                begin
                    if (is_dig) begin
                        if (s.acc > MAX_LEN_DIV10)
                            r.phase = PH_BAD;
                        else begin
                            r.acc   = acc_new;
                            r.phase = (acc_new > MAX_LEN) ? PH_BAD : PH_DIGITS;
                        end
                    end
                    else if (is_ws) begin
                        if (s.phase == PH_DIGITS)
                            r.phase = PH_TRAILWS;
                    end
                    else
                        r.phase = PH_BAD;
                end
                PH_TRAILWS:
                begin
                    if (!is_ws)
                        r.phase = PH_BAD;
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

endpackage

[hw/rtl/http_header_length_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_length_scanner
// Scans an http request head byte by byte and reports status and content length.
// ----------------------------------------------------------------------------
// channel   handshake                        payload
// input     push / full  (push && !full)     data_byte[7:0]
// result    pop / empty  (pop && !empty)     status[2:0], has_length, body_length[26:0]
// config    cfg_valid / cfg_ready            max_header_bytes[20:0]
//
// one byte per cycle sustained while full is low; the parser updates its line state once per word
// with no backlog a result reaches the result ports once its LF word has left the word queue
// and the parser has written it into the result queue; a 4-word queue splits intake from the
// parser, a 2-word queue holds results; full rises only when the word queue fills behind a stalled result side
// rst_n clears all state but the queue storage and sets the limit to 8192; cfg_ready is always high
// ----------------------------------------------------------------------------
module http_header_length_scanner
    import hhls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         data_byte,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         status,
    output logic               has_length,
    output logic [LEN_W-1:0]   body_length,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] max_header_bytes
);

    logic    tok_valid;
    token_t  tok;
    logic    tok_pop;
    result_t res_head;

    assign cfg_ready = 1'b1;

    hhls_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .full      (full),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    hhls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (max_header_bytes),
        .res_empty (empty),
        .res_pop   (pop),
        .res_head  (res_head)
    );

    assign status      = res_head.status;
    assign has_length  = res_head.has_length;
    assign body_length = res_head.body_length;

endmodule

[hw/rtl/hhls_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhls_front
// Byte intake: folds CR handling into words and queues them for the parser.
// ----------------------------------------------------------------------------
module hhls_front
    import hhls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] data_byte,
    output logic       full,
    output logic       tok_valid,
    output token_t     tok,
    input  logic       tok_pop
);

    token_t              tok_mem [TOK_DEPTH];
    logic [TOK_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [TOK_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [TOK_CW-1:0]   count_reg, count_next;
    logic                cr_pending_reg, cr_pending_next;
    logic                accept;
    logic                tok_push;
    token_t              new_tok;

    assign full      = (count_reg == TOK_CW'(TOK_DEPTH));
    assign accept    = push && !full;
    assign tok_valid = (count_reg != '0);
    assign tok       = tok_mem[rd_ptr_reg];

    always_comb
    begin
        tok_push        = 1'b0;
        new_tok         = '0;
        cr_pending_next = cr_pending_reg;
        if (accept) begin
            if (data_byte == CHAR_LF) begin
                // a CR right before LF is dropped
                tok_push        = 1'b1;
                new_tok.eol     = 1'b1;
                cr_pending_next = 1'b0;
            end
            else if (data_byte == CHAR_CR) begin
                // the earlier CR turns out to be content
                tok_push        = cr_pending_reg;
                new_tok.data    = CHAR_CR;
                cr_pending_next = 1'b1;
            end
            else begin
                tok_push         = 1'b1;
                new_tok.cr_first = cr_pending_reg;
                new_tok.data     = data_byte;
                cr_pending_next  = 1'b0;
            end
        end
        wr_ptr_next = tok_push ? wr_ptr_reg + TOK_AW'(1) : wr_ptr_reg;
        rd_ptr_next = tok_pop ? rd_ptr_reg + TOK_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + TOK_CW'(tok_push) - TOK_CW'(tok_pop);
    end

    always_ff @(posedge clk)
    begin
        if (tok_push)
            tok_mem[wr_ptr_reg] <= new_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            cr_pending_reg <= 1'b0;
        end
        else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            cr_pending_reg <= cr_pending_next;
        end
    end

    a_tok_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= TOK_CW'(TOK_DEPTH))
        else $error("word queue count beyond depth");

    a_lf_clears_cr: assert property (@(posedge clk) disable iff (!rst_n)
        accept && data_byte == CHAR_LF |=> !cr_pending_reg)
        else $error("cr pending survived a line end");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tok_pop |-> tok_valid)
        else $error("word popped from empty queue");

endmodule

[hw/rtl/hhls_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhls_back
// Line parser: request line, header limit and content-length checks, result queue.
// ----------------------------------------------------------------------------
module hhls_back
    import hhls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  token_t             tok,
    output logic               tok_pop,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    output logic               res_empty,
    input  logic               res_pop,
    output result_t            res_head
);

    line_t               line_reg, line_next;
    logic [LEN_W-1:0]    stored_reg, stored_next;
    logic                seen_reg, seen_next;
    logic [LIMIT_W-1:0]  limit_reg;
    result_t             res_mem [RES_DEPTH];
    logic                res_wr_reg, res_rd_reg;
    logic [RES_CW-1:0]   res_count_reg, res_count_next;
    logic                res_push;
    logic                res_take;
    result_t             res_new;
    line_t               line_cr;
    logic [COUNT_W-1:0]  count_eol;

    assign res_empty = (res_count_reg == '0);
    assign res_take  = res_pop && !res_empty;
    assign res_head  = res_mem[res_rd_reg];
    assign tok_pop   = tok_valid && (!tok.eol || res_count_reg != RES_CW'(RES_DEPTH));
    assign line_cr   = tok.cr_first ? take_content(line_reg, CHAR_CR) : line_reg;
    assign count_eol = sat_add(line_reg.count, 2'd2);

    always_comb
    begin
        line_next   = line_reg;
        stored_next = stored_reg;
        seen_next   = seen_reg;
        res_push    = 1'b0;
        res_new     = '0;
        if (tok_pop) begin
            if (!tok.eol)
                line_next = take_content(line_cr, tok.data);
            else begin
                if (!line_reg.in_hdr) begin
                    if (!line_reg.nonempty) begin
                        res_push       = 1'b1;
                        res_new.status = ST_EMPTY;
                    end
                    else if (line_reg.space_cnt < 2'd2) begin
                        res_push       = 1'b1;
                        res_new.status = ST_BADLINE;
                    end
                    else begin
                        line_next.count = count_eol;
                        line_next.in_hdr = 1'b1;
                    end
                end
                else if (!line_reg.nonempty) begin
                    // blank line ends the head
                    res_push            = 1'b1;
                    res_new.status      = ST_OK;
                    res_new.has_length  = seen_reg;
                    res_new.body_length = seen_reg ? stored_reg : '0;
                end
                else begin
                    line_next.count = count_eol;
                    if (count_eol > COUNT_W'(limit_reg)) begin
                        res_push       = 1'b1;
                        res_new.status = ST_TOOLARGE;
                    end
                    else if (line_reg.phase == PH_BAD || line_reg.phase == PH_LEADWS) begin
                        res_push       = 1'b1;
                        res_new.status = ST_MALFORMED;
                    end
                    else if (line_reg.phase == PH_DIGITS ||
                             line_reg.phase == PH_TRAILWS) begin
                        if (seen_reg && stored_reg != line_reg.acc) begin
                            res_push       = 1'b1;
                            res_new.status = ST_MALFORMED;
                        end
                        else begin
                            seen_next   = 1'b1;
                            stored_next = line_reg.acc;
                        end
                    end
                end
                // next line starts fresh
                line_next.nonempty = 1'b0;
                line_next.phase    = PH_PREFIX;
                line_next.pidx     = 4'd0;
                line_next.acc      = '0;
                if (res_push) begin
                    line_next   = LINE_RESET;
                    stored_next = '0;
                    seen_next   = 1'b0;
                end
            end
        end
        res_count_next = res_count_reg + RES_CW'(res_push) - RES_CW'(res_take);
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_mem[res_wr_reg] <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_reg      <= LINE_RESET;
            stored_reg    <= '0;
            seen_reg      <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            res_wr_reg    <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_count_reg <= '0;
        end
        else begin
            line_reg      <= line_next;
            stored_reg    <= stored_next;
            seen_reg      <= seen_next;
            if (cfg_we)
                limit_reg <= cfg_data;
            if (res_push)
                res_wr_reg <= !res_wr_reg;
            if (res_take)
                res_rd_reg <= !res_rd_reg;
            res_count_reg <= res_count_next;
        end
    end

    a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= RES_CW'(RES_DEPTH))
        else $error("result queue count beyond depth");

    a_err_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_new.status != ST_OK |-> !res_new.has_length &&
                                                res_new.body_length == '0)
        else $error("length reported with an error status");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !line_reg.in_hdr && line_reg.count == '0 && !seen_reg)
        else $error("parser did not restart after a result");

endmodule

[verif/http_header_length_scanner_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_length_scanner_checker
// Watches the byte, result and limit channels of the scanner, predicts the
// outcome of every request head from the accepted bytes and compares each
// popped result field by field against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module http_header_length_scanner_checker
    import hhls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [7:0]         data_byte,
    input  logic               empty,
    input  logic               pop,
    input  logic [2:0]         status,
    input  logic               has_length,
    input  logic [LEN_W-1:0]   body_length,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [LIMIT_W-1:0] max_header_bytes,
    output int                 fail_count,
    output int                 pending_results
);

    localparam logic [8*15-1:0] LEN_KEY       = "content-length:";
    localparam logic [LEN_W-1:0] LEN_CAP       = 27'd67108864;
    localparam logic [LEN_W-1:0] LEN_CAP_TENTH = 27'd6710886;

    // predicted parser state
    logic [LIMIT_W-1:0] limit;
    bit                 hdr_mode;
    logic [1:0]         spaces;
    bit                 cr_held;
    bit                 line_used;
    logic [31:0]        head_bytes;
    phase_t             scan_phase;
    logic [3:0]         key_pos;
    logic [LEN_W-1:0]   digits_val;
    logic [LEN_W-1:0]   kept_len;
    bit                 kept_valid;

    result_t            expected_outcomes[$];
    int                 mismatches;
    int                 depth;
    bit                 got;
    result_t            outcome;
    result_t            oldest;

    assign fail_count      = mismatches;
    assign pending_results = depth;

    task automatic clear_line_state();
        cr_held    = 1'b0;
        line_used  = 1'b0;
        scan_phase = PH_PREFIX;
        key_pos    = 4'd0;
        digits_val = '0;
    endtask

    task automatic restart_scan();
        hdr_mode   = 1'b0;
        spaces     = 2'd0;
        head_bytes = 32'd0;
        kept_len   = '0;
        kept_valid = 1'b0;
        clear_line_state();
    endtask

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    task automatic bump(input logic [31:0] n);
        if (head_bytes > 32'hFFFF_FFFF - n)
            head_bytes = 32'hFFFF_FFFF;
        else
            head_bytes = head_bytes + n;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [7:0]   lc;
        logic [7:0]   key_char;
        logic [LEN_W:0] nxt;
        line_used = 1'b1;
        bump(32'd1);
        if (!hdr_mode)
        begin
            if (c == CHAR_SPACE && spaces < 2'd2)
                spaces = spaces + 2'd1;
        end
        else
        begin
            case (scan_phase) inside
                PH_PREFIX:
                begin
                    lc       = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
                    key_char = (key_pos < 4'd15) ? LEN_KEY[8*(14 - key_pos) +: 8] : 8'h00;
                    if (key_pos < 4'd15 && lc == key_char)
                    begin
                        key_pos = key_pos + 4'd1;
                        if (key_pos == 4'd15)
                            scan_phase = PH_LEADWS;
                    end
                    else
                        scan_phase = PH_OTHER;
                end
                PH_LEADWS, PH_DIGITS:
                begin
                    if (c >= 8'h30 && c <= 8'h39)
                    begin
                        if (digits_val > LEN_CAP_TENTH)
                            scan_phase = PH_BAD;
                        else
                        begin
                            nxt        = (LEN_W+1)'(digits_val) * 28'd10 + (LEN_W+1)'(c - 8'h30);
                            digits_val = nxt[LEN_W-1:0];
                            scan_phase = (nxt > (LEN_W+1)'(LEN_CAP)) ? PH_BAD : PH_DIGITS;
                        end
                    end
                    else if (is_blank(c))
                    begin
                        if (scan_phase == PH_DIGITS)
                            scan_phase = PH_TRAILWS;
                    end
                    else
                        scan_phase = PH_BAD;
                end
                PH_TRAILWS:
                begin
                    if (!is_blank(c))
                        scan_phase = PH_BAD;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic finish_scan(input status_t st, input bit has, input logic [LEN_W-1:0] len,
                               output result_t r);
        r.status      = st;
        r.has_length  = has;
        r.body_length = has ? len : '0;
        restart_scan();
    endtask

    task automatic close_line(output bit hit, output result_t r);
        hit = 1'b0;
        r   = '0;
        if (!hdr_mode)
        begin
            if (!line_used)
            begin
                finish_scan(ST_EMPTY, 1'b0, '0, r);
                hit = 1'b1;
            end
            else if (spaces < 2'd2)
            begin
                finish_scan(ST_BADLINE, 1'b0, '0, r);
                hit = 1'b1;
            end
            else
            begin
                bump(32'd2);
                hdr_mode = 1'b1;
                clear_line_state();
            end
        end
        else if (!line_used)
        begin
            // blank line closes the head
            finish_scan(ST_OK, kept_valid, kept_len, r);
            hit = 1'b1;
        end
        else
        begin
            bump(32'd2);
            if (head_bytes > 32'(limit))
            begin
                finish_scan(ST_TOOLARGE, 1'b0, '0, r);
                hit = 1'b1;
            end
            else if (scan_phase == PH_BAD || scan_phase == PH_LEADWS)
            begin
                finish_scan(ST_MALFORMED, 1'b0, '0, r);
                hit = 1'b1;
            end
            else
            begin
                if (scan_phase == PH_DIGITS || scan_phase == PH_TRAILWS)
                begin
                    if (kept_valid && kept_len != digits_val)
                    begin
                        finish_scan(ST_MALFORMED, 1'b0, '0, r);
                        hit = 1'b1;
                    end
                    else
                    begin
                        kept_valid = 1'b1;
                        kept_len   = digits_val;
                    end
                end
                if (!hit)
                    clear_line_state();
            end
        end
    endtask

    task automatic scan_byte(input logic [7:0] c, output bit hit, output result_t r);
        hit = 1'b0;
        r   = '0;
        if (c == CHAR_LF)
        begin
            cr_held = 1'b0;
            close_line(hit, r);
        end
        else
        begin
            // a held cr that is not followed by lf is an ordinary line byte
            if (cr_held)
            begin
                cr_held = 1'b0;
                absorb_char(CHAR_CR);
            end
            if (c == CHAR_CR)
                cr_held = 1'b1;
            else
                absorb_char(c);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit = LIMIT_RESET;
            restart_scan();
            expected_outcomes.delete();
            mismatches = 0;
            depth      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit = max_header_bytes;
            if (pop && !empty)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: expected no result word, actual status %0d has_length %0d length %0d",
                             $time, status, has_length, body_length);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_outcomes.pop_front();
                    if (status !== 3'(oldest.status))
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.status, status);
                        mismatches++;
                    end
                    if (has_length !== oldest.has_length)
                    begin
                        $display("%0t: has_length expected %0d actual %0d",
                                 $time, oldest.has_length, has_length);
                        mismatches++;
                    end
                    if (body_length !== oldest.body_length)
                    begin
                        $display("%0t: body_length expected %0d actual %0d",
                                 $time, oldest.body_length, body_length);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
            begin
                scan_byte(data_byte, got, outcome);
                if (got)
                    expected_outcomes.insert(expected_outcomes.size(), outcome);
            end
            depth = expected_outcomes.size();
        end
    end

endmodule

[verif/tb_http_header_length_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_header_length_scanner
// Feeds the scanner directed and randomized request heads under several head
// limits, with random gaps on the byte side and random stalls on the result
// side; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_http_header_length_scanner;
    import hhls_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic [7:0]         data_byte;
    logic               full;
    logic               empty;
    logic               pop;
    logic [2:0]         status;
    logic               has_length;
    logic [LEN_W-1:0]   body_length;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] max_header_bytes;
    int                 fail_count;
    int                 pending_results;

    logic [7:0]         request_bytes[$];
    bit                 no_gaps;
    int                 pop_hold;
    int                 bytes_sent;
    int                 limit_step;

    http_header_length_scanner uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .data_byte        (data_byte),
        .full             (full),
        .empty            (empty),
        .pop              (pop),
        .status           (status),
        .has_length       (has_length),
        .body_length      (body_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .max_header_bytes (max_header_bytes)
    );

    http_header_length_scanner_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .data_byte        (data_byte),
        .empty            (empty),
        .pop              (pop),
        .status           (status),
        .has_length       (has_length),
        .body_length      (body_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .max_header_bytes (max_header_bytes),
        .fail_count       (fail_count),
        .pending_results  (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls
    initial
    begin
        pop      = 1'b0;
        pop_hold = 0;
        forever
        begin
            @(negedge clk);
            if (pop_hold > 0)
            begin
                pop <= 1'b0;
                pop_hold--;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    pop_hold = pick_gap();
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_request();
        while (request_bytes.size() > 0)
            send_byte(request_bytes.pop_front());
    endtask

    // wait until every predicted result word has been popped, then drain
    task automatic settle();
        push <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid        <= 1'b1;
        max_header_bytes <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_byte(input logic [7:0] b);
        request_bytes.insert(request_bytes.size(), b);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_eol();
        if ($urandom_range(0, 2) != 0)
            add_byte(CHAR_CR);
        add_byte(CHAR_LF);
    endtask

    task automatic add_token(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_byte(8'($urandom_range(33, 126)));
    endtask

    task automatic add_blank();
        case ($urandom_range(0, 4))
            0: add_byte(8'h09);
            1: add_byte(8'h0B);
            2: add_byte(8'h0C);
            3: add_byte(CHAR_CR);
            default: add_byte(CHAR_SPACE);
        endcase
    endtask

    // any byte but lf
    task automatic add_noise(input int n);
        int i;
        logic [7:0] b;
        for (i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            add_byte(b == CHAR_LF ? 8'h0B : b);
        end
    endtask

    // first n characters of the length key in random case
    task automatic add_key(input int n);
        string key;
        logic [7:0] ch;
        int i;
        key = "content-length:";
        for (i = 0; i < n; i++)
        begin
            ch = key[i];
            if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1) == 1)
                ch = ch - 8'd32;
            add_byte(ch);
        end
    endtask

    task automatic add_request_line();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            add_token($urandom_range(1, 3));
            add_byte(CHAR_SPACE);
            add_token($urandom_range(1, 4));
            add_byte(CHAR_SPACE);
            if ($urandom_range(0, 4) == 0)
                add_byte(CHAR_SPACE);
            add_token($urandom_range(1, 3));
        end
        else if (r < 88)
        begin
            add_token($urandom_range(1, 4));
            if ($urandom_range(0, 1) == 1)
            begin
                add_byte(CHAR_SPACE);
                add_token($urandom_range(0, 3));
            end
        end
        else if (r < 94)
        begin
        end
        else
            add_noise($urandom_range(1, 6));
        add_eol();
    endtask

    task automatic add_length_line();
        int kind;
        int v;
        int i;
        add_key(15);
        repeat ($urandom_range(0, 2)) add_blank();
        kind = $urandom_range(0, 99);
        v    = -1;
        if (kind < 40)
            v = $urandom_range(0, 3);
        else if (kind < 55)
            v = $urandom_range(0, 99999);
        else if (kind < 65)
            v = 67108864;
        else if (kind < 72)
            v = 67108865;
        else if (kind < 78)
            v = $urandom_range(67108866, 999999999);
        else if (kind < 88)
        begin
            // leading zeros leave the value untouched
            for (i = 0; i < $urandom_range(1, 12); i++)
                add_byte(8'h30);
            v = $urandom_range(0, 9);
        end
        if (v >= 0)
            add_text($sformatf("%0d", v));
        repeat ($urandom_range(0, 2)) add_blank();
        if ($urandom_range(0, 11) == 0)
            add_byte(8'($urandom_range(33, 126)));
        add_eol();
    endtask

    task automatic add_header_line();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            add_length_line();
        else
        begin
            if (r < 75)
            begin
                add_token($urandom_range(1, 5));
                add_byte(8'h3A);
                add_byte(CHAR_SPACE);
                add_token($urandom_range(0, 6));
            end
            else if (r < 85)
                add_key($urandom_range(1, 14));
            else if (r < 95)
                add_noise($urandom_range(1, 8));
            else
            begin
                add_key($urandom_range(0, 13));
                add_byte(8'h58);
                add_token($urandom_range(0, 3));
            end
            add_eol();
        end
    endtask

    task automatic build_request();
        if ($urandom_range(0, 99) < 5)
        begin
            repeat ($urandom_range(1, 12))
                add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_request_line();
            repeat ($urandom_range(0, 4)) add_header_line();
            if ($urandom_range(0, 99) < 92)
                add_eol();
        end
    endtask

    function automatic logic [LIMIT_W-1:0] next_limit(input int step);
        case (step % 8)
            0: return 21'd0;
            1: return 21'd1;
            2: return 21'($urandom_range(20, 120));
            3: return LIMIT_RESET;
            4: return 21'd1048576;
            5: return 21'h1FFFFF;
            6: return 21'($urandom_range(30, 200));
            default: return 21'($urandom_range(0, 2097151));
        endcase
    endfunction

    initial
    begin
        rst_n            = 1'b0;
        push             = 1'b0;
        data_byte        = 8'h00;
        cfg_valid        = 1'b0;
        max_header_bytes = '0;
        no_gaps          = 1'b0;
        bytes_sent       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty request, also with a dropped cr
        add_text("\n");
        send_request();
        add_text("\r\n");
        send_request();
        // extreme bytes, one space only: bad request line
        add_byte(8'h00);
        add_byte(CHAR_SPACE);
        add_byte(8'hFF);
        add_byte(CHAR_LF);
        send_request();
        // minimal head with no headers
        add_text("  \n\n");
        send_request();
        // a zero limit rejects any header line
        settle();
        write_limit(21'd0);
        add_text("  \nx\n");
        send_request();

        limit_step = 1;
        while (bytes_sent < 1200)
        begin
            settle();
            write_limit(next_limit(limit_step));
            limit_step++;
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 8))
            begin
                build_request();
                send_request();
            end
        end

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/hhls_pkg.sv
hw/rtl/hhls_front.sv
hw/rtl/hhls_back.sv
hw/rtl/http_header_length_scanner.sv
verif/http_header_length_scanner_checker.sv
verif/tb_http_header_length_scanner.sv
